// ----- rtl/ipr_pkg.sv -----
// Shared types, register offsets and helpers for the interrupt and power register block.
`timescale 1ns / 1ps
`default_nettype none

package ipr_pkg;

    // Access kind carried in the input tuser
    typedef enum logic [1:0] {
        FUNC_READ    = 2'd0,
        FUNC_WRITE   = 2'd1,
        FUNC_REQUEST = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    // Register offsets above the I/O base
    localparam logic [9:0] ADDR_IME      = 10'h208;
    localparam logic [7:0] WORD_IME      = 8'h82;   // 0x208..0x20B
    localparam logic [7:0] WORD_IE       = 8'h84;   // 0x210..0x213
    localparam logic [7:0] WORD_IF       = 8'h85;   // 0x214..0x217
    localparam logic [9:0] ADDR_POSTBOOT = 10'h300;
    localparam logic [9:0] ADDR_HALT     = 10'h301;

    localparam logic [31:0] BOOT_PC_LIMIT = 32'h0000_7FFF;

    localparam int IE_W = 25;

    typedef struct packed {
        logic [1:0]      halt_mode;
        logic            post_boot_flag;
        logic [31:0]     pending_flags;
        logic [IE_W-1:0] enable_mask;
        logic            master_enable;
    } t_ipr_state;

    typedef struct packed {
        logic [31:0] cpu_pc;
        logic [31:0] request_bits;
        logic [7:0]  write_data;
        logic [9:0]  reg_addr;
        t_func       func;
    } t_ipr_item;

    typedef struct packed {
        logic       unmapped;
        logic       stop_request;
        logic [1:0] halt_mode_out;
        logic       irq_line;
        logic [7:0] read_data;
    } t_ipr_result;

    // Writable bits of each enable mask byte
    function automatic logic [7:0] ie_take(input logic [1:0] k);
        logic [7:0] m;
        unique case (k)
            2'd0: m = 8'hFF;
            2'd1: m = 8'h3F;
            2'd2: m = 8'hDF;
            default: m = 8'h01;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ipr_core.sv -----
// Decode one access or request and form the next register state and the result beat.
`timescale 1ns / 1ps
`default_nettype none

module ipr_core (
    input  wire ipr_pkg::t_ipr_state  i_state,
    input  wire ipr_pkg::t_ipr_item   i_item,
    output ipr_pkg::t_ipr_state       o_state,
    output ipr_pkg::t_ipr_result      o_result
);

    logic [7:0]  w_word;
    logic [1:0]  w_k;
    logic        w_hit_ime;
    logic        w_hit_ie;
    logic        w_hit_if;
    logic        w_hit_pb;
    logic        w_hit_halt;
    logic        w_mapped;
    logic        w_reeval;
    logic [31:0] w_ie_full;
    logic [31:0] w_ie_new;
    logic [31:0] w_byte_sh;
    logic [7:0]  w_rdata;
    ipr_pkg::t_ipr_state w_next;

    assign w_word     = i_item.reg_addr[9:2];
    assign w_k        = i_item.reg_addr[1:0];
    assign w_hit_ime  = (w_word == ipr_pkg::WORD_IME);
    assign w_hit_ie   = (w_word == ipr_pkg::WORD_IE);
    assign w_hit_if   = (w_word == ipr_pkg::WORD_IF);
    assign w_hit_pb   = (i_item.reg_addr == ipr_pkg::ADDR_POSTBOOT);
    assign w_hit_halt = (i_item.reg_addr == ipr_pkg::ADDR_HALT);
    assign w_mapped   = w_hit_ime || w_hit_ie || w_hit_if || w_hit_pb || w_hit_halt;

    assign w_ie_full = {{(32 - ipr_pkg::IE_W){1'b0}}, i_state.enable_mask};
    assign w_byte_sh = {24'd0, i_item.write_data} << {w_k, 3'b000};
    assign w_ie_new  = (w_ie_full & ~(32'hFF << {w_k, 3'b000}))
                     | ({24'd0, i_item.write_data & ipr_pkg::ie_take(w_k)} << {w_k, 3'b000});

    // Read mux
    always_comb begin
        w_rdata = 8'd0;
        if (w_hit_ime) begin
            w_rdata = (w_k == 2'd0) ? {7'd0, i_state.master_enable} : 8'd0;
        end else if (w_hit_ie) begin
            w_rdata = 8'(w_ie_full >> {w_k, 3'b000});
        end else if (w_hit_if) begin
            w_rdata = 8'(i_state.pending_flags >> {w_k, 3'b000});
        end else if (w_hit_pb) begin
            w_rdata = {7'd0, i_state.post_boot_flag};
        end else if (w_hit_halt) begin
            w_rdata = {i_state.halt_mode, 6'd0};
        end
    end

    // Apply the access; IE, IF, IME and request updates wake halt on an enabled IRQ
    always_comb begin
        w_next   = i_state;
        w_reeval = 1'b0;
        o_result = '0;
        unique case (i_item.func)
            ipr_pkg::FUNC_READ: begin
                o_result.read_data = w_rdata;
                o_result.unmapped  = !w_mapped;
            end
            ipr_pkg::FUNC_WRITE: begin
                o_result.unmapped = !w_mapped;
                if (w_hit_ime && w_k == 2'd0) begin
                    w_next.master_enable = i_item.write_data[0];
                    w_reeval = 1'b1;
                end else if (w_hit_ie) begin
                    w_next.enable_mask = w_ie_new[ipr_pkg::IE_W-1:0];
                    w_reeval = 1'b1;
                end else if (w_hit_if) begin
                    w_next.pending_flags = i_state.pending_flags & ~w_byte_sh;
                    w_reeval = 1'b1;
                end else if (w_hit_pb) begin
                    if (i_item.cpu_pc <= ipr_pkg::BOOT_PC_LIMIT) begin
                        w_next.post_boot_flag = i_state.post_boot_flag | i_item.write_data[0];
                    end
                end else if (w_hit_halt) begin
                    w_next.halt_mode      = i_item.write_data[7:6];
                    o_result.stop_request = i_item.write_data[6];
                end
            end
            ipr_pkg::FUNC_REQUEST: begin
                w_next.pending_flags = i_state.pending_flags | i_item.request_bits;
                w_reeval = 1'b1;
            end
            default: begin
            end
        endcase

        o_state = w_next;
        if (w_reeval && |(w_next.enable_mask & w_next.pending_flags[ipr_pkg::IE_W-1:0])) begin
            o_state.halt_mode = 2'd0;
        end
        o_result.halt_mode_out = o_state.halt_mode;
        o_result.irq_line = o_state.master_enable
                          && |(o_state.enable_mask & o_state.pending_flags[ipr_pkg::IE_W-1:0]);
    end

endmodule

`default_nettype wire

// ----- rtl/ipr_regs.sv -----
// Architectural registers: master enable, enable mask, pending flags, post-boot flag, halt mode.
`timescale 1ns / 1ps
`default_nettype none

module ipr_regs (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_update,
    input  wire ipr_pkg::t_ipr_state  i_next,
    output ipr_pkg::t_ipr_state       o_state
);

    ipr_pkg::t_ipr_state r_state;
    ipr_pkg::t_ipr_state n_state;

    // Take the new state when an item retires
    always_comb begin
        n_state = i_update ? i_next : r_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// ----- rtl/interrupt_and_power_registers.sv -----
// Top level of the interrupt and power register block with input and result registers.
`timescale 1ns / 1ps
`default_nettype none

// Byte-wide interrupt and power register block. Each input beat is a byte read, a byte write
// or an interrupt request (tuser selects which); each gives exactly one result beat with the
// read byte, the IRQ line, the halt mode, a stop request and an unmapped-address flag. One
// beat is accepted every clock unless the result side stalls; a beat goes through an input
// register and the decode and register update logic into a result register, from which its
// result is offered. A stalled result register holds the input stage, and the input register
// frees in the same cycle that the result is taken. Reset clears all state to zero.
module interrupt_and_power_registers (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [9:0] reg_addr, [17:10] write_data, [49:18] request_bits, [81:50] cpu_pc, rest zero
    input  wire  [87:0] i_s_axis_tdata,
    // [1:0] func
    input  wire  [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [7:0] read_data, [8] irq_line, [10:9] halt_mode_out, [11] stop_request,
    // [12] unmapped, rest zero
    output logic [15:0] o_m_axis_tdata
);

    logic                  r_in_valid;
    logic                  n_in_valid;
    ipr_pkg::t_ipr_item    r_in;
    logic                  r_out_valid;
    logic                  n_out_valid;
    ipr_pkg::t_ipr_result  r_out;
    logic                  w_advance;
    logic                  w_accept;
    ipr_pkg::t_ipr_item    w_item;
    ipr_pkg::t_ipr_state   w_state;
    ipr_pkg::t_ipr_state   w_next;
    ipr_pkg::t_ipr_result  w_result;

    // Move a beat into the result register when it is empty or being drained
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_item.func         = ipr_pkg::t_func'(i_s_axis_tuser);
    assign w_item.reg_addr     = i_s_axis_tdata[9:0];
    assign w_item.write_data   = i_s_axis_tdata[17:10];
    assign w_item.request_bits = i_s_axis_tdata[49:18];
    assign w_item.cpu_pc       = i_s_axis_tdata[81:50];

    always_comb begin
        n_in_valid  = w_accept ? 1'b1 : (w_advance ? 1'b0 : r_in_valid);
        n_out_valid = w_advance ? 1'b1 : (i_m_axis_tready ? 1'b0 : r_out_valid);
    end

    // Handshake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= w_item;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    ipr_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_advance),
        .i_next   (w_next),
        .o_state  (w_state)
    );

    ipr_core u_core (
        .i_state  (w_state),
        .i_item   (r_in),
        .o_state  (w_next),
        .o_result (w_result)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out};

    // A held result matches the register state it was computed with
    a_irq_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.irq_line == (w_state.master_enable
            && |(w_state.enable_mask & w_state.pending_flags[ipr_pkg::IE_W-1:0]))))
        else $error("irq_line does not match register state");

    a_halt_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.halt_mode_out == w_state.halt_mode))
        else $error("halt_mode_out does not match register state");

    a_stop_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stop_request) |-> r_out.halt_mode_out[0])
        else $error("stop request without stop halt mode");

    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.unmapped) |-> (r_out.read_data == 8'd0))
        else $error("unmapped access returned nonzero data");

endmodule

`default_nettype wire

// ----- tb/ipr_result_checker.sv -----
// Result checker for the interrupt and power register block: predicts and compares each beat.
`timescale 1ns / 1ps

module ipr_result_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    // [9:0] reg_addr, [17:10] write_data, [49:18] request_bits, [81:50] cpu_pc, rest zero
    input  wire  [87:0] i_s_tdata,
    // [1:0] func
    input  wire  [1:0]  i_s_tuser,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    // [7:0] read_data, [8] irq_line, [10:9] halt_mode_out, [11] stop_request,
    // [12] unmapped, rest zero
    input  wire  [15:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_outstanding
);

    // Writable bits of the enable mask, byte 0 in the lowest bits
    localparam logic [31:0] IE_WRITABLE = 32'h01DF_3FFF;

    ipr_pkg::t_ipr_state  shadow_regs;
    ipr_pkg::t_ipr_result expected_results[$];
    int                   fail_count;
    int                   outstanding_count;
    int                   result_index;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding_count;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result beat %0d on %s: got 0x%0h, expected 0x%0h",
                 result_index, what, got, want);
        fail_count++;
    endtask

    // Apply one access to the shadow registers and return the result it gives
    function automatic ipr_pkg::t_ipr_result step_registers(input ipr_pkg::t_func func,
                                                            input logic [9:0] addr,
                                                            input logic [7:0] wdata,
                                                            input logic [31:0] req,
                                                            input logic [31:0] pc);
        ipr_pkg::t_ipr_result r;
        logic [31:0] ie_wide;
        logic        mapped;
        logic        recheck;
        int          k;
        r       = '0;
        k       = int'(addr[1:0]);
        mapped  = 1'b1;
        recheck = 1'b0;
        ie_wide = {7'd0, shadow_regs.enable_mask};
        case (func)
            ipr_pkg::FUNC_READ: begin
                if (addr == ipr_pkg::ADDR_IME)
                    r.read_data = {7'd0, shadow_regs.master_enable};
                else if (addr[9:2] == ipr_pkg::WORD_IME)
                    r.read_data = 8'd0;
                else if (addr[9:2] == ipr_pkg::WORD_IE)
                    r.read_data = ie_wide[8*k +: 8];
                else if (addr[9:2] == ipr_pkg::WORD_IF)
                    r.read_data = shadow_regs.pending_flags[8*k +: 8];
                else if (addr == ipr_pkg::ADDR_POSTBOOT)
                    r.read_data = {7'd0, shadow_regs.post_boot_flag};
                else if (addr == ipr_pkg::ADDR_HALT)
                    r.read_data = {shadow_regs.halt_mode, 6'd0};
                else
                    mapped = 1'b0;
            end
            ipr_pkg::FUNC_WRITE: begin
                if (addr == ipr_pkg::ADDR_IME) begin
                    shadow_regs.master_enable = wdata[0];
                    recheck = 1'b1;
                end else if (addr[9:2] == ipr_pkg::WORD_IME) begin
                    // reserved bytes of the master enable word: nothing to store
                end else if (addr[9:2] == ipr_pkg::WORD_IE) begin
                    ie_wide[8*k +: 8] = wdata & IE_WRITABLE[8*k +: 8];
                    shadow_regs.enable_mask = ie_wide[ipr_pkg::IE_W-1:0];
                    recheck = 1'b1;
                end else if (addr[9:2] == ipr_pkg::WORD_IF) begin
                    shadow_regs.pending_flags[8*k +: 8] =
                        shadow_regs.pending_flags[8*k +: 8] & ~wdata;
                    recheck = 1'b1;
                end else if (addr == ipr_pkg::ADDR_POSTBOOT) begin
                    // the flag only sets, and only while still in boot code
                    if (pc <= ipr_pkg::BOOT_PC_LIMIT)
                        shadow_regs.post_boot_flag = shadow_regs.post_boot_flag | wdata[0];
                end else if (addr == ipr_pkg::ADDR_HALT) begin
                    // modes 1 and 3 are the odd ones: both ask the CPU to stop
                    shadow_regs.halt_mode = wdata[7:6];
                    r.stop_request        = wdata[6];
                end else begin
                    mapped = 1'b0;
                end
            end
            ipr_pkg::FUNC_REQUEST: begin
                shadow_regs.pending_flags = shadow_regs.pending_flags | req;
                recheck = 1'b1;
            end
            default: begin
            end
        endcase
        // Wake from halt when an enable, flag or request update leaves an enabled IRQ pending
        if (recheck && (({7'd0, shadow_regs.enable_mask} & shadow_regs.pending_flags) != 0))
            shadow_regs.halt_mode = 2'd0;
        r.unmapped      = ~mapped;
        r.halt_mode_out = shadow_regs.halt_mode;
        r.irq_line      = shadow_regs.master_enable &
                          (|({7'd0, shadow_regs.enable_mask} & shadow_regs.pending_flags));
        return r;
    endfunction

    // Check the result beat against the oldest expectation, then predict the new input beat
    always @(posedge i_clk) begin
        ipr_pkg::t_ipr_result got;
        ipr_pkg::t_ipr_result want;
        if (!i_rst_n) begin
            shadow_regs = '0;
            expected_results.delete();
            fail_count        = 0;
            result_index      = 0;
            outstanding_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat", {16'd0, i_m_tdata}, 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    got  = ipr_pkg::t_ipr_result'(i_m_tdata[12:0]);
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", 32'(got.read_data),
                                        32'(want.read_data));
                    if (got.irq_line !== want.irq_line)
                        report_mismatch("irq_line", 32'(got.irq_line), 32'(want.irq_line));
                    if (got.halt_mode_out !== want.halt_mode_out)
                        report_mismatch("halt_mode_out", 32'(got.halt_mode_out),
                                        32'(want.halt_mode_out));
                    if (got.stop_request !== want.stop_request)
                        report_mismatch("stop_request", 32'(got.stop_request),
                                        32'(want.stop_request));
                    if (got.unmapped !== want.unmapped)
                        report_mismatch("unmapped", 32'(got.unmapped), 32'(want.unmapped));
                    if (i_m_tdata[15:13] !== 3'd0)
                        report_mismatch("padding", 32'(i_m_tdata[15:13]), 32'd0);
                end
                result_index++;
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(step_registers(ipr_pkg::t_func'(i_s_tuser),
                                                          i_s_tdata[9:0], i_s_tdata[17:10],
                                                          i_s_tdata[49:18],
                                                          i_s_tdata[81:50]));
            outstanding_count = expected_results.size();
        end
    end

endmodule

// ----- tb/tb_interrupt_and_power_registers.sv -----
// Testbench top for the interrupt and power register block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_interrupt_and_power_registers;

    localparam int RANDOM_ITEMS = 1175;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_START   = 600;
    localparam int HOLD_CYCLES  = 150;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    int          fail_count;
    int          outstanding_count;
    int          idle_run;

    interrupt_and_power_registers u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    ipr_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding_count)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Offer one beat at the falling edge and hold it until it is taken
    task automatic send_beat(input ipr_pkg::t_func f, input logic [9:0] addr,
                             input logic [7:0] wdata, input logic [31:0] req,
                             input logic [31:0] pc);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {6'd0, pc, req, wdata, addr};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Drop valid for the given number of cycles
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic drain_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (outstanding_count != 0) @(negedge i_clk);
    endtask

    // One random access, weighted toward the mapped registers
    task automatic send_random_item();
        int             pick;
        int             sel;
        ipr_pkg::t_func f;
        logic [9:0]     addr;
        logic [31:0]    req;
        logic [31:0]    pc;
        pick = $urandom_range(0, 99);
        if (pick < 40)      f = ipr_pkg::FUNC_READ;
        else if (pick < 85) f = ipr_pkg::FUNC_WRITE;
        else if (pick < 96) f = ipr_pkg::FUNC_REQUEST;
        else                f = ipr_pkg::FUNC_NONE;
        sel = $urandom_range(0, 19);
        case (sel)
            0, 1, 2, 3:     addr = {ipr_pkg::WORD_IME, 2'(sel)};
            4, 5, 6, 7:     addr = {ipr_pkg::WORD_IE, 2'(sel)};
            8, 9, 10, 11:   addr = {ipr_pkg::WORD_IF, 2'(sel)};
            12, 13:         addr = ipr_pkg::ADDR_POSTBOOT;
            14, 15:         addr = ipr_pkg::ADDR_HALT;
            default:        addr = 10'($urandom_range(0, 1023));
        endcase
        case ($urandom_range(0, 3))
            0, 1:    req = $urandom;
            2:       req = 32'd1 << $urandom_range(0, 31);
            default: req = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
        endcase
        case ($urandom_range(0, 3))
            0:       pc = 32'($urandom_range(0, 32'h7FFF));
            1:       pc = ($urandom_range(0, 1) != 0) ? ipr_pkg::BOOT_PC_LIMIT
                                                      : ipr_pkg::BOOT_PC_LIMIT + 1;
            default: pc = $urandom;
        endcase
        send_beat(f, addr, 8'($urandom_range(0, 255)), req, pc);
    endtask

    // Stimulus and verdict
    initial begin
        int burst_left;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = ipr_pkg::FUNC_READ;
        s_tdata  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset values, mask widths, halt and wake, post-boot gate, unmapped, func 3
        send_beat(ipr_pkg::FUNC_READ, ipr_pkg::ADDR_IME, 8'h00, 32'd0, 32'd0);
        for (int k = 0; k < 4; k++)
            send_beat(ipr_pkg::FUNC_WRITE, {ipr_pkg::WORD_IE, 2'(k)}, 8'hFF, 32'd0, 32'd0);
        send_beat(ipr_pkg::FUNC_READ, {ipr_pkg::WORD_IE, 2'd1}, 8'h00, 32'd0, 32'd0);
        send_beat(ipr_pkg::FUNC_READ, {ipr_pkg::WORD_IE, 2'd2}, 8'h00, 32'd0, 32'd0);
        send_beat(ipr_pkg::FUNC_WRITE, ipr_pkg::ADDR_HALT, 8'h40, 32'd0, 32'd0);
        send_beat(ipr_pkg::FUNC_REQUEST, 10'h000, 8'h00, 32'hFFFF_FFFF, 32'd0);
        send_beat(ipr_pkg::FUNC_WRITE, ipr_pkg::ADDR_IME, 8'hFF, 32'd0, 32'd0);
        send_beat(ipr_pkg::FUNC_WRITE, ipr_pkg::ADDR_HALT, 8'hC0, 32'd0, 32'd0);
        send_beat(ipr_pkg::FUNC_WRITE, ipr_pkg::ADDR_HALT, 8'h80, 32'd0, 32'd0);
        send_beat(ipr_pkg::FUNC_READ, ipr_pkg::ADDR_HALT, 8'h00, 32'd0, 32'd0);
        for (int k = 3; k >= 0; k--)
            send_beat(ipr_pkg::FUNC_WRITE, {ipr_pkg::WORD_IF, 2'(k)}, 8'hFF, 32'd0, 32'd0);
        send_beat(ipr_pkg::FUNC_WRITE, ipr_pkg::ADDR_POSTBOOT, 8'hFF, 32'd0,
                  ipr_pkg::BOOT_PC_LIMIT + 1);
        send_beat(ipr_pkg::FUNC_READ, ipr_pkg::ADDR_POSTBOOT, 8'h00, 32'd0, 32'hFFFF_FFFF);
        send_beat(ipr_pkg::FUNC_WRITE, ipr_pkg::ADDR_POSTBOOT, 8'h01, 32'd0,
                  ipr_pkg::BOOT_PC_LIMIT);
        send_beat(ipr_pkg::FUNC_WRITE, {ipr_pkg::WORD_IME, 2'd1}, 8'hFF, 32'd0, 32'd0);
        send_beat(ipr_pkg::FUNC_READ, {ipr_pkg::WORD_IME, 2'd3}, 8'h00, 32'd0, 32'd0);
        send_beat(ipr_pkg::FUNC_READ, 10'h000, 8'h00, 32'd0, 32'd0);
        send_beat(ipr_pkg::FUNC_WRITE, 10'h3FF, 8'hFF, 32'd0, 32'd0);
        send_beat(ipr_pkg::FUNC_NONE, ipr_pkg::ADDR_IME, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(ipr_pkg::FUNC_WRITE, ipr_pkg::ADDR_IME, 8'h00, 32'd0, 32'd0);
        drain_results();

        // Random bursts with random gaps, one full drain partway through
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            if (burst_left == 0) begin
                idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
                burst_left = $urandom_range(1, 40);
            end
            send_random_item();
            burst_left--;
        end
        drain_results();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && outstanding_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side: a random ready pattern per window of cycles, with one long hold-off
    initial begin
        int mode;
        int cycle;
        m_tready = 1'b0;
        mode     = 0;
        cycle    = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (cycle % 64 == 0)
                mode = $urandom_range(0, 3);
            if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES)
                m_tready <= 1'b0;
            else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((cycle % 5) < 3);
                endcase
            end
            cycle++;
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n)
            idle_run <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_run <= 0;
        else if (idle_run >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else
            idle_run <= idle_run + 1;
    end

endmodule

// ----- filelist.f -----
rtl/ipr_pkg.sv
rtl/ipr_core.sv
rtl/ipr_regs.sv
rtl/interrupt_and_power_registers.sv
tb/ipr_result_checker.sv
tb/tb_interrupt_and_power_registers.sv
